FILE: rtl/core/iorr_pkg.sv
// Shared constants for the in-order response reorder core.
`timescale 1ns / 1ps

package iorr_pkg;

    localparam int unsigned IORR_WINDOW       = 16;
    localparam int unsigned IORR_SEQ_BITS     = 16;
    localparam int unsigned IORR_PAYLOAD_BITS = 64;

endpackage

FILE: rtl/core/iorr_slot_store.sv
// Parked-payload memory with per-slot valid marks.
`timescale 1ns / 1ps

module iorr_slot_store #(
    parameter int unsigned WINDOW       = iorr_pkg::IORR_WINDOW,
    parameter int unsigned PAYLOAD_BITS = iorr_pkg::IORR_PAYLOAD_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [$clog2(WINDOW)-1:0]       wr_addr,
    input  logic [PAYLOAD_BITS-1:0]         wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(WINDOW)-1:0]       rd_addr,
    output logic [PAYLOAD_BITS-1:0]         rd_data,
    input  logic                            clr_en,
    input  logic [$clog2(WINDOW)-1:0]       clr_addr,
    input  logic [$clog2(WINDOW)-1:0]       peek_addr,
    output logic                            peek_valid
);

    import iorr_pkg::*;

    logic [PAYLOAD_BITS-1:0] mem [WINDOW];
    logic [PAYLOAD_BITS-1:0] rd_data_reg;
    logic [WINDOW-1:0]       valid_reg;
    logic [WINDOW-1:0]       valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (clr_en)
        begin
            valid_next[clr_addr] = 1'b0;
        end
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign peek_valid = valid_reg[peek_addr];

endmodule

FILE: rtl/core/in_order_response_reorder_core.sv
// Top level of the in-order response reorder core.
//
//   channel | signals                                 | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, seq_number, payload,  | sink
//           | link_open                               |
//   out     | out_valid/out_ready, out_payload,        | source
//           | out_seq, status, last                   |
//
// A word that parks, drops or is rejected leaves the sequencer idle; in_ready is high
// whenever the sequencer is idle and the output register is free or emptying.
// An in-order word releases at once; each parked entry behind it then goes
// through a slot memory read and then an output load, so a run of parked
// entries holds the input until the run drains, and longer under any output stall.
// Reset clears the expected number, the window head and all valid marks at once.
`timescale 1ns / 1ps

module in_order_response_reorder_core #(
    parameter int unsigned WINDOW       = iorr_pkg::IORR_WINDOW,
    parameter int unsigned SEQ_BITS     = iorr_pkg::IORR_SEQ_BITS,
    parameter int unsigned PAYLOAD_BITS = iorr_pkg::IORR_PAYLOAD_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SEQ_BITS-1:0]     seq_number,
    input  logic [PAYLOAD_BITS-1:0] payload,
    input  logic                    link_open,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [PAYLOAD_BITS-1:0] out_payload,
    output logic [SEQ_BITS-1:0]     out_seq,
    output logic                    status,
    output logic                    last
);

    import iorr_pkg::*;

    localparam int unsigned AW = $clog2(WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                  state_reg,     state_next;
    logic [AW-1:0]           head_reg,      head_next;
    logic [SEQ_BITS-1:0]     expected_reg,  expected_next;
    logic                    out_valid_reg, out_valid_next;
    logic [PAYLOAD_BITS-1:0] out_pay_reg,   out_pay_next;
    logic [SEQ_BITS-1:0]     out_seq_reg,   out_seq_next;
    logic                    out_status_reg, out_status_next;
    logic                    out_last_reg,  out_last_next;

    logic                    out_free;
    logic                    accept;
    logic [SEQ_BITS-1:0]     seq_gap;
    logic                    out_of_window;
    logic [AW:0]             park_sum;
    logic [AW-1:0]           park_addr;
    logic [AW-1:0]           head_inc;

    logic                    wr_en;
    logic                    rd_en;
    logic                    clr_en;
    logic [PAYLOAD_BITS-1:0] rd_data;
    logic                    peek_valid;

    assign out_free      = !out_valid_reg || out_ready;
    assign in_ready      = (state_reg == ST_IDLE) && out_free;
    assign accept        = in_valid && in_ready;
    assign seq_gap       = seq_number - expected_reg;
    assign out_of_window = (33'(seq_gap) >= 33'(WINDOW));
    assign park_sum      = {1'b0, head_reg} + {1'b0, AW'(seq_gap)};
    assign park_addr     = (park_sum >= (AW+1)'(WINDOW))
                         ? AW'(park_sum - (AW+1)'(WINDOW)) : AW'(park_sum);
    assign head_inc      = (head_reg == AW'(WINDOW - 1)) ? '0 : head_reg + AW'(1);

    assign wr_en  = accept && link_open && !out_of_window && (seq_gap != '0);
    assign rd_en  = (state_reg == ST_READ);
    assign clr_en = (state_reg == ST_EMIT) && out_free;

    iorr_slot_store #(
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_slot_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (park_addr),
        .wr_data    (payload),
        .rd_en      (rd_en),
        .rd_addr    (head_reg),
        .rd_data    (rd_data),
        .clr_en     (clr_en),
        .clr_addr   (head_reg),
        .peek_addr  (head_inc),
        .peek_valid (peek_valid)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        expected_next   = expected_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_pay_next    = out_pay_reg;
        out_seq_next    = out_seq_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && link_open)
                begin
                    if (out_of_window)
                    begin
                        out_valid_next  = 1'b1;
                        out_pay_next    = '0;
                        out_seq_next    = seq_number;
                        out_status_next = 1'b1;
                        out_last_next   = 1'b1;
                    end
                    else if (seq_gap == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_pay_next    = payload;
                        out_seq_next    = seq_number;
                        out_status_next = 1'b0;
                        out_last_next   = !peek_valid;
                        head_next       = head_inc;
                        expected_next   = expected_reg + SEQ_BITS'(1);
                        if (peek_valid)
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_pay_next    = rd_data;
                    out_seq_next    = expected_reg;
                    out_status_next = 1'b0;
                    out_last_next   = !peek_valid;
                    head_next       = head_inc;
                    expected_next   = expected_reg + SEQ_BITS'(1);
                    state_next      = peek_valid ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            expected_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            expected_reg  <= expected_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pay_reg    <= out_pay_next;
        out_seq_reg    <= out_seq_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_payload = out_pay_reg;
    assign out_seq     = out_seq_reg;
    assign status      = out_status_reg;
    assign last        = out_last_reg;

`ifndef SYNTHESIS
    a_run_open_while_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (state_reg != ST_IDLE))
        else $error("drain run ended without a last word");

    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg) |-> out_last_reg)
        else $error("rejected word not marked last");

    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_EMIT))
        else $error("slot read not followed by emit");

    a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free) |=>
            (expected_reg == $past(expected_reg) + SEQ_BITS'(1)))
        else $error("expected number did not advance on release");
`endif

endmodule

FILE: tb/in_order_response_reorder_core_tb.sv
// Testbench for the in-order response reorder core: directed and random words checked in order.
`timescale 1ns / 1ps

module in_order_response_reorder_core_tb;

    import iorr_pkg::*;

    localparam int unsigned WIN = IORR_WINDOW;
    localparam int unsigned WAW = $clog2(WIN);
    localparam int unsigned SB  = IORR_SEQ_BITS;
    localparam int unsigned PB  = IORR_PAYLOAD_BITS;

    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned SETTLE_TIME  = 2 * WIN + 8;
    localparam int unsigned HOLDOFF_TIME = 300;

    typedef enum logic {
        ST_IN_ORDER      = 1'b0,
        ST_OUT_OF_WINDOW = 1'b1
    } status_e;

    typedef struct packed {
        logic [PB-1:0] pay;
        logic [SB-1:0] seq;
        status_e       stat;
        logic          fin;
    } release_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [SB-1:0] seq_number;
    logic [PB-1:0] payload;
    logic          link_open;
    logic          out_valid;
    logic          out_ready;
    logic [PB-1:0] out_payload;
    logic [SB-1:0] out_seq;
    logic          status;
    logic          last;

    logic [SB-1:0] next_seq;
    logic          parked[WIN];
    logic [PB-1:0] parked_pay[WIN];
    release_t      pending_releases[$];

    int unsigned   idle_pct;
    int unsigned   stall_pct;
    int unsigned   hold_left;
    int unsigned   mismatch_count;
    int unsigned   quiet_cycles;

    in_order_response_reorder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .seq_number  (seq_number),
        .payload     (payload),
        .link_open   (link_open),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_payload (out_payload),
        .out_seq     (out_seq),
        .status      (status),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [PB-1:0] rand_word64();
        return PB'({$urandom, $urandom});
    endfunction

    function automatic void queue_release(input release_t r);
        pending_releases.insert(pending_releases.size(), r);
    endfunction

    function automatic void track_word(input logic [SB-1:0] s, input logic [PB-1:0] p,
                                       input logic open);
        logic [SB-1:0] offset;
        release_t      r;
        int unsigned   n;
        if (!open)
            return;
        offset = s - next_seq;
        if (offset >= WIN)
        begin
            r = '{pay: '0, seq: s, stat: ST_OUT_OF_WINDOW, fin: 1'b1};
            queue_release(r);
            return;
        end
        if (offset != 0)
        begin
            parked[offset[WAW-1:0]]     = 1'b1;
            parked_pay[offset[WAW-1:0]] = p;
            return;
        end
        r = '{pay: p, seq: s, stat: ST_IN_ORDER, fin: 1'b0};
        n = 0;
        forever
        begin
            n++;
            next_seq = next_seq + 1'b1;
            for (int k = 0; k + 1 < WIN; k++)
            begin
                parked[k]     = parked[k + 1];
                parked_pay[k] = parked_pay[k + 1];
            end
            parked[WIN - 1]     = 1'b0;
            parked_pay[WIN - 1] = '0;
            r.fin = !parked[0] || (n >= WIN);
            queue_release(r);
            if (r.fin)
                break;
            r.pay = parked_pay[0];
            r.seq = next_seq;
        end
    endfunction

    task automatic send_word(input logic [SB-1:0] s, input logic [PB-1:0] p,
                             input logic open);
        in_valid   <= 1'b1;
        seq_number <= s;
        payload    <= p;
        link_open  <= open;
        do
            @(posedge clk);
        while (!in_ready);
        track_word(s, p, open);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_releases.size() != 0);
    endtask

    task automatic send_blocks(input int unsigned n_words);
        int unsigned   sent;
        int unsigned   len;
        int unsigned   j;
        int unsigned   tmp;
        int unsigned   order[WIN];
        logic [SB-1:0] base;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(99) < 20)
            begin
                case ($urandom_range(2))
                    0: send_word(SB'($urandom), rand_word64(), 1'b0);
                    1: send_word(SB'($urandom), rand_word64(), 1'b1);
                    default: send_word(next_seq - SB'(1 + $urandom_range(20)),
                                       rand_word64(), 1'b1);
                endcase
                sent++;
            end
            else
            begin
                base = next_seq;
                len  = $urandom_range(WIN, 1);
                for (int i = 0; i < WIN; i++)
                    order[i] = i;
                for (int i = int'(len) - 1; i > 0; i--)
                begin
                    j        = $urandom_range(i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < int'(len); i++)
                begin
                    if ($urandom_range(99) < 10)
                    begin
                        send_word(base + SB'(order[i]), rand_word64(), 1'b1);
                        sent++;
                    end
                    send_word(base + SB'(order[i]), rand_word64(), 1'b1);
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input int unsigned n_words);
        idle_pct  = idle;
        stall_pct = stall;
        send_blocks(n_words);
        drain_wait();
    endtask

    task automatic test_directed_cases();
        idle_pct  = 0;
        stall_pct = 0;
        send_word(16'd0, '1, 1'b1);
        send_word(16'd1, {PB/2{2'b01}}, 1'b0);
        send_word(16'd3, '0, 1'b1);
        send_word(16'd2, '1, 1'b1);
        send_word(16'd3, {PB/8{8'hA5}}, 1'b1);
        send_word(16'd1, PB'(64'h0123_4567_89AB_CDEF), 1'b1);
        send_word(16'd19, rand_word64(), 1'b1);
        send_word(16'd20, rand_word64(), 1'b1);
        send_word(16'hFFFF, '1, 1'b1);
        for (int s = 5; s <= 18; s++)
            send_word(SB'(s), rand_word64(), 1'b1);
        send_word(16'd4, '0, 1'b1);
        send_word(16'd20, '1, 1'b0);
        drain_wait();
    endtask

    task automatic test_no_idle();
        run_phase(0, 0, 20);
    endtask

    task automatic test_sender_idle();
        run_phase(80, 0, 20);
    endtask

    task automatic test_receiver_stall();
        run_phase(0, 80, 20);
    endtask

    task automatic test_both_idle();
        run_phase(26, 26, 20);
    endtask

    task automatic test_output_holdoff();
        hold_left = HOLDOFF_TIME;
        run_phase(0, 0, 12);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        release_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_releases.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: pay=%h seq=%h status=%0d last=%0d",
                                 out_payload, out_seq, status, last);
                end
                else
                begin
                    want = pending_releases.pop_front();
                    if (out_payload !== want.pay || out_seq !== want.seq ||
                        status !== want.stat || last !== want.fin)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected pay=%h seq=%h status=%0d last=%0d,",
                                     want.pay, want.seq, want.stat, want.fin,
                                     " got pay=%h seq=%h status=%0d last=%0d",
                                     out_payload, out_seq, status, last);
                    end
                end
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        next_seq       = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_left      = 0;
        mismatch_count = 0;
        for (int k = 0; k < WIN; k++)
        begin
            parked[k]     = 1'b0;
            parked_pay[k] = '0;
        end
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        seq_number <= '0;
        payload    <= '0;
        link_open  <= 1'b0;
        out_ready  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_output_holdoff();

        drain_wait();
        repeat (SETTLE_TIME) @(posedge clk);
        if (mismatch_count == 0 && pending_releases.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
